// ===== hw/rtl/fupc_pkg.sv =====
// fupc_pkg: shared types, character constants and helper functions for the
// form-urlencoded percent codec. No dependencies.
package fupc_pkg;

   // Characters with special meaning
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   // Codec mode register values
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Partial decode sequence: nothing held, '%' held, '%' and one hex digit held
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_PCT  = 2'd1;
   localparam logic [1:0] PEND_HEX  = 2'd2;

   // hex_value result for a byte that is not a hex digit
   localparam logic [4:0] HEX_NONE = 5'd16;

   // Up to three output bytes of one input item, in order
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            last;
   } fupc_entry_type;

   // Front-end state seen by the top level
   typedef struct packed {
      logic       mode;
      logic [1:0] pend;
   } fupc_front_stat_type;

   // 0..15 for a hex digit of either case, HEX_NONE otherwise
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = HEX_NONE;
      if (b inside {[8'h30:8'h39]}) begin
         v = {1'b0, b[3:0]};
      end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         v = 5'(b[3:0]) + 5'd9;
      end
      return v;
   endfunction

   // Letters, digits and the three unreserved marks pass through
   function automatic logic is_unreserved(input logic [7:0] b);
      return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
             (b == CH_MINUS) || (b == CH_DOT) || (b == CH_UNDER);
   endfunction

   // Uppercase hex digit for one nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] d;
      if (nib < 4'd10) begin
         d = {4'h3, nib};
      end else begin
         d = 8'(nib) + 8'h37;
      end
      return d;
   endfunction

endpackage

// ===== hw/rtl/fupc_front.sv =====
// fupc_front: accepts input items, holds the mode register and the partial
// decode state, and turns each item into a queue entry of 0..3 bytes. Uses fupc_pkg.
module fupc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_in_last,
   input  logic                          q_full,
   output logic                          q_push,
   output fupc_pkg::fupc_entry_type      q_entry,
   output fupc_pkg::fupc_front_stat_type stat
);

   logic       mode_ff, mode_in;
   logic [1:0] pend_ff, pend_in;
   logic [7:0] hold_ff, hold_in;

   logic       accept;
   logic [4:0] hv;
   logic [3:0] hi_nib;
   logic       plain_put;
   logic [7:0] plain_byte;
   logic       plain_pct;
   logic [7:0] ebuf [4];
   logic [2:0] ecnt;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Plain decode of the current byte (no sequence pending)
   assign hv         = fupc_pkg::hex_value(req_in_byte);
   assign hi_nib     = 4'(fupc_pkg::hex_value(hold_ff));
   assign plain_pct  = (req_in_byte == fupc_pkg::CH_PERCENT);
   assign plain_put  = !plain_pct;
   assign plain_byte = (req_in_byte == fupc_pkg::CH_PLUS) ? fupc_pkg::CH_SPACE : req_in_byte;

   // Classify the item: output bytes and next partial-sequence state
   always_comb begin
      pend_in = pend_ff;
      hold_in = hold_ff;
      ecnt    = 3'd0;
      for (int i = 0; i < 4; i++) begin
         ebuf[i] = '0;
      end
      if (mode_ff == fupc_pkg::MODE_DECODE) begin
         case (pend_ff)
            fupc_pkg::PEND_PCT: begin
               if (!hv[4]) begin
                  hold_in = req_in_byte;
                  pend_in = fupc_pkg::PEND_HEX;
               end else begin
                  pend_in = fupc_pkg::PEND_NONE;
                  ebuf[ecnt[1:0]] = fupc_pkg::CH_PERCENT;
                  ecnt = ecnt + 3'd1;
                  if (plain_put) begin
                     ebuf[ecnt[1:0]] = plain_byte;
                     ecnt = ecnt + 3'd1;
                  end else begin
                     pend_in = fupc_pkg::PEND_PCT;
                  end
               end
            end
            fupc_pkg::PEND_HEX: begin
               pend_in = fupc_pkg::PEND_NONE;
               if (!hv[4]) begin
                  ebuf[ecnt[1:0]] = {hi_nib, hv[3:0]};
                  ecnt = ecnt + 3'd1;
               end else begin
                  ebuf[ecnt[1:0]] = fupc_pkg::CH_PERCENT;
                  ecnt = ecnt + 3'd1;
                  ebuf[ecnt[1:0]] = hold_ff;
                  ecnt = ecnt + 3'd1;
                  if (plain_put) begin
                     ebuf[ecnt[1:0]] = plain_byte;
                     ecnt = ecnt + 3'd1;
                  end else begin
                     pend_in = fupc_pkg::PEND_PCT;
                  end
               end
               hold_in = '0;
            end
            default: begin
               pend_in = fupc_pkg::PEND_NONE;
               if (plain_put) begin
                  ebuf[ecnt[1:0]] = plain_byte;
                  ecnt = ecnt + 3'd1;
               end else begin
                  pend_in = fupc_pkg::PEND_PCT;
               end
            end
         endcase
         // Last byte flushes a partial sequence literally; a fourth output byte is dropped
         if (req_in_last) begin
            if (pend_in == fupc_pkg::PEND_PCT) begin
               ebuf[ecnt[1:0]] = fupc_pkg::CH_PERCENT;
               ecnt = ecnt + 3'd1;
            end else if (pend_in == fupc_pkg::PEND_HEX) begin
               ebuf[ecnt[1:0]] = fupc_pkg::CH_PERCENT;
               ecnt = ecnt + 3'd1;
               ebuf[ecnt[1:0]] = hold_in;
               ecnt = ecnt + 3'd1;
            end
            pend_in = fupc_pkg::PEND_NONE;
            hold_in = '0;
         end
      end else begin
         // Encode
         pend_in = fupc_pkg::PEND_NONE;
         hold_in = '0;
         if (req_in_byte == fupc_pkg::CH_SPACE) begin
            ebuf[0] = fupc_pkg::CH_PLUS;
            ecnt    = 3'd1;
         end else if (fupc_pkg::is_unreserved(req_in_byte)) begin
            ebuf[0] = req_in_byte;
            ecnt    = 3'd1;
         end else begin
            ebuf[0] = fupc_pkg::CH_PERCENT;
            ebuf[1] = fupc_pkg::hex_digit(req_in_byte[7:4]);
            ebuf[2] = fupc_pkg::hex_digit(req_in_byte[3:0]);
            ecnt    = 3'd3;
         end
      end
      if (ecnt > 3'd3) begin
         ecnt = 3'd3;
      end
   end

   // Queue entry; absorbed bytes push nothing
   assign q_entry.bytes = {ebuf[2], ebuf[1], ebuf[0]};
   assign q_entry.count = ecnt[1:0];
   assign q_entry.last  = req_in_last;
   assign q_push        = accept && (ecnt != 3'd0);

   // Mode register write clears any partial sequence
   always_comb begin
      mode_in = mode_ff;
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= fupc_pkg::MODE_ENCODE;
         pend_ff <= fupc_pkg::PEND_NONE;
         hold_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         if (csr_wr_en) begin
            pend_ff <= fupc_pkg::PEND_NONE;
            hold_ff <= '0;
         end else if (accept) begin
            pend_ff <= pend_in;
            hold_ff <= hold_in;
         end
      end
   end

   assign stat.mode = mode_ff;
   assign stat.pend = pend_ff;

endmodule

// ===== hw/rtl/fupc_queue.sv =====
// fupc_queue: small FIFO of classified items between the front and back ends.
// Uses fupc_pkg for the entry type.
module fupc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  fupc_pkg::fupc_entry_type entry_in,
   input  logic                     pop,
   output fupc_pkg::fupc_entry_type entry_out,
   output logic                     full,
   output logic                     empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   fupc_pkg::fupc_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign entry_out = mem_ff[rd_ptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ===== hw/rtl/fupc_back.sv =====
// fupc_back: takes queue entries and sends their bytes one per cycle, while rsp_stall
// is low, on the result channel with run_last and string_end. Uses fupc_pkg.
module fupc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  fupc_pkg::fupc_entry_type q_entry,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_run_last,
   output logic                     rsp_string_end
);

   fupc_pkg::fupc_entry_type cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       is_final;
   logic       take;

   assign is_final = (idx_ff == (cur_ff.count - 2'd1));
   assign take     = busy_ff && !rsp_stall;
   assign q_pop    = !q_empty && (!busy_ff || (take && is_final));

   // Step through the bytes of the current entry
   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (q_pop) begin
         cur_in  = q_entry;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (take) begin
         if (is_final) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_valid      = busy_ff;
   assign rsp_out_byte   = cur_ff.bytes[idx_ff];
   assign rsp_run_last   = is_final;
   assign rsp_string_end = is_final && cur_ff.last;

endmodule

// ===== hw/rtl/form_url_percent_codec.sv =====
// form_url_percent_codec: form-urlencoded percent encoder/decoder, top level.
// The first result of an item is offered once the item has been written into the queue
// and then loaded from there into the back end's entry register.
// Throughput: one result byte per cycle while rsp_stall is low, at the back end's single
// output port; an item gives 1 to 3 bytes, and absorbed decode bytes give none.
// Reset (synchronous, active high) selects encode mode and clears the partial
// sequence, the queue and the output stage; no clearing pass.
module form_url_percent_codec #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);

   fupc_pkg::fupc_entry_type      push_entry;
   fupc_pkg::fupc_entry_type      pop_entry;
   fupc_pkg::fupc_front_stat_type front_stat;
   logic q_push, q_pop, q_full, q_empty;

   // Front end: classify items
   fupc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry),
      .stat        (front_stat)
   );

   // Decoupling queue
   fupc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .entry_in  (push_entry),
      .pop       (q_pop),
      .entry_out (pop_entry),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back end: serialize result bytes
   fupc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_entry        (pop_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   // A last item never leaves a partial sequence behind
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_in_last && !csr_wr_en)
         |=> (front_stat.pend == fupc_pkg::PEND_NONE))
      else $error("partial sequence survives last item");

   // Encode mode never holds a partial sequence
   assert property (@(posedge clock) disable iff (reset)
      (front_stat.mode == fupc_pkg::MODE_ENCODE) |-> (front_stat.pend == fupc_pkg::PEND_NONE))
      else $error("pending sequence in encode mode");

   // Result channel goes idle only after the final byte of an item is taken
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(rsp_valid)) |-> $past(rsp_run_last && !rsp_stall))
      else $error("result stream dropped mid-item");

endmodule

// ===== tb/tb_form_url_percent_codec.sv =====
// tb_form_url_percent_codec: self-checking testbench for the form-urlencoded percent codec.
// Depends on fupc_pkg and form_url_percent_codec. A queue-fed driver and a monitor run
// against a built-in byte-level predictor, through directed strings and random phases.
`timescale 1ns / 1ps

module tb_form_url_percent_codec;

   localparam int unsigned IDLE_LIMIT = 3000;  // cycles with no handshake before giving up
   localparam int unsigned LONG_HOLD  = 120;   // receiver hold-off that backs up the block
   localparam int unsigned TAIL       = 8;     // settle cycles after the last result

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } in_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       str_end;
   } out_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_string_end;

   form_url_percent_codec dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   // Stimulus and expectation stores
   in_item_type    req_items[$];
   in_item_type    cur_item;
   out_beat_type   out_bytes_due[$];
   out_beat_type   due_beat;

   // Predictor state: mode plus partial percent sequence
   logic        mode_shadow = fupc_pkg::MODE_ENCODE;
   logic [1:0]  held_count  = fupc_pkg::PEND_NONE;
   logic [7:0]  held_digit  = 8'h00;

   // Traffic shaping, set by the sequencer
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          sender_hold = 1'b0;
   int unsigned long_hold_req = 0;
   int unsigned long_hold_done = 0;
   int unsigned hold_left = 0;

   // Bookkeeping
   int unsigned items_accepted = 0;
   int unsigned encode_items = 0;
   int unsigned decode_items = 0;
   int unsigned strings_sent = 0;
   int unsigned results_checked = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(input string msg);
      error_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   // 0..15 for a hex digit in either case, HEX_NONE for anything else
   function automatic logic [4:0] nibble_of(input logic [7:0] b);
      logic [7:0] low;
      low = b | 8'h20;
      if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
      if (low >= 8'h61 && low <= 8'h66) return 5'(low - 8'h57);
      return fupc_pkg::HEX_NONE;
   endfunction

   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      return (n > 4'd9) ? 8'(n) + 8'd55 : 8'(n) + 8'd48;
   endfunction

   function automatic bit passes_plain(input logic [7:0] b);
      logic [7:0] low;
      low = b | 8'h20;
      return (b >= 8'h30 && b <= 8'h39) || (low >= 8'h61 && low <= 8'h7A) ||
             b == fupc_pkg::CH_MINUS || b == fupc_pkg::CH_DOT || b == fupc_pkg::CH_UNDER;
   endfunction

   // Work out the output bytes of one accepted input byte and queue them
   task automatic expand_input_byte(input logic [7:0] b, input logic last);
      logic [7:0] outs[$];
      logic [4:0] nib;
      logic [4:0] hi;
      bit         reexamine;
      out_beat_type beat;
      int         n;
      reexamine = 1'b0;
      if (mode_shadow == fupc_pkg::MODE_DECODE) begin
         nib = nibble_of(b);
         case (held_count)
            fupc_pkg::PEND_PCT: begin
               if (nib != fupc_pkg::HEX_NONE) begin
                  held_digit = b;
                  held_count = fupc_pkg::PEND_HEX;
               end else begin
                  held_count = fupc_pkg::PEND_NONE;
                  outs.push_back(fupc_pkg::CH_PERCENT);
                  reexamine = 1'b1;
               end
            end
            fupc_pkg::PEND_HEX: begin
               held_count = fupc_pkg::PEND_NONE;
               hi = nibble_of(held_digit);
               if (nib != fupc_pkg::HEX_NONE) begin
                  outs.push_back({hi[3:0], nib[3:0]});
               end else begin
                  outs.push_back(fupc_pkg::CH_PERCENT);
                  outs.push_back(held_digit);
                  reexamine = 1'b1;
               end
               held_digit = 8'h00;
            end
            default: begin
               held_count = fupc_pkg::PEND_NONE;
               reexamine = 1'b1;
            end
         endcase
         // byte seen with no sequence open
         if (reexamine) begin
            if (b == fupc_pkg::CH_PLUS) outs.push_back(fupc_pkg::CH_SPACE);
            else if (b == fupc_pkg::CH_PERCENT) held_count = fupc_pkg::PEND_PCT;
            else outs.push_back(b);
         end
         // end of string flushes a partial sequence literally
         if (last) begin
            if (held_count == fupc_pkg::PEND_PCT) begin
               outs.push_back(fupc_pkg::CH_PERCENT);
            end else if (held_count == fupc_pkg::PEND_HEX) begin
               outs.push_back(fupc_pkg::CH_PERCENT);
               outs.push_back(held_digit);
            end
            held_count = fupc_pkg::PEND_NONE;
            held_digit = 8'h00;
         end
      end else begin
         held_count = fupc_pkg::PEND_NONE;
         held_digit = 8'h00;
         if (b == fupc_pkg::CH_SPACE) begin
            outs.push_back(fupc_pkg::CH_PLUS);
         end else if (passes_plain(b)) begin
            outs.push_back(b);
         end else begin
            outs.push_back(fupc_pkg::CH_PERCENT);
            outs.push_back(nibble_char(b[7:4]));
            outs.push_back(nibble_char(b[3:0]));
         end
      end
      // at most three bytes per item; a fourth from a flush is dropped
      n = (outs.size() > 3) ? 3 : outs.size();
      for (int k = 0; k < n; k++) begin
         beat.data     = outs[k];
         beat.run_last = (k == n - 1);
         beat.str_end  = (k == n - 1) && last;
         out_bytes_due.push_back(beat);
      end
   endtask

   // Driver: presents queued items, predicts each one at its handshake
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expand_input_byte(cur_item.data, cur_item.last);
            items_accepted++;
            if (mode_shadow == fupc_pkg::MODE_DECODE) decode_items++;
            else encode_items++;
            if (cur_item.last) strings_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (!sender_hold && req_items.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               cur_item = req_items.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= cur_item.data;
               req_in_last <= cur_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: random, or a long counted hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (long_hold_done != long_hold_req) begin
         long_hold_done++;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Monitor: compare each result byte with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (out_bytes_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result byte %h", rsp_out_byte));
         end else begin
            due_beat = out_bytes_due.pop_front();
            results_checked++;
            if (rsp_out_byte !== due_beat.data)
               flag_mismatch($sformatf("out_byte %h, expected %h",
                                       rsp_out_byte, due_beat.data));
            if (rsp_run_last !== due_beat.run_last)
               flag_mismatch($sformatf("run_last %b, expected %b (byte %h)",
                                       rsp_run_last, due_beat.run_last, due_beat.data));
            if (rsp_string_end !== due_beat.str_end)
               flag_mismatch($sformatf("string_end %b, expected %b (byte %h)",
                                       rsp_string_end, due_beat.str_end, due_beat.data));
         end
      end
   end

   // Watchdog: too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] timeout: no handshake for %0d cycles, %0d results outstanding",
                  $realtime, idle_cycles, out_bytes_due.size());
         $display("form_url_percent_codec verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_item(input logic [7:0] b, input logic last);
      in_item_type it;
      it.data = b;
      it.last = last;
      req_items.push_back(it);
   endtask

   task automatic push_text(input string s, input bit end_last);
      for (int i = 0; i < s.len(); i++) push_item(s[i], end_last && (i == s.len() - 1));
   endtask

   // Wait until every item is in and every result is out, then let the pipe settle
   task automatic wait_idle();
      do @(negedge clock);
      while (req_items.size() != 0 || req_valid || out_bytes_due.size() != 0);
      repeat (TAIL) @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // mode write drops any partial sequence
      mode_shadow = m;
      held_count = fupc_pkg::PEND_NONE;
      held_digit = 8'h00;
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_hex_char();
      logic [7:0] c;
      c = nibble_char(4'($urandom_range(15)));
      if (c > 8'h39 && $urandom_range(1) == 1) c = c | 8'h20;
      return c;
   endfunction

   // One encode string: letters, digits, marks, spaces and arbitrary bytes
   task automatic gen_encode_string();
      int         len;
      int         r;
      logic [7:0] b;
      len = $urandom_range(10, 1);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(99);
         if (r < 15) b = fupc_pkg::CH_SPACE;
         else if (r < 25) b = 8'h61 + 8'($urandom_range(25));
         else if (r < 35) b = 8'h41 + 8'($urandom_range(25));
         else if (r < 42) b = 8'h30 + 8'($urandom_range(9));
         else if (r < 48) b = ($urandom_range(2) == 0) ? fupc_pkg::CH_MINUS :
                              ($urandom_range(1) == 0) ? fupc_pkg::CH_DOT :
                              fupc_pkg::CH_UNDER;
         else b = 8'($urandom_range(255));
         push_item(b, i == len - 1);
      end
   endtask

   // One decode string: mostly well-formed escapes, some broken or cut short
   task automatic gen_decode_string();
      logic [7:0] seg[$];
      int         want_len;
      int         r;
      want_len = $urandom_range(10, 1);
      while (seg.size() < want_len) begin
         r = $urandom_range(99);
         if (r < 40) begin
            seg.push_back(fupc_pkg::CH_PERCENT);
            seg.push_back(random_hex_char());
            seg.push_back(random_hex_char());
         end else if (r < 50) begin
            seg.push_back(fupc_pkg::CH_PLUS);
         end else if (r < 70) begin
            seg.push_back(8'($urandom_range(255)));
         end else if (r < 85) begin
            seg.push_back(fupc_pkg::CH_PERCENT);
            if ($urandom_range(1) == 1) seg.push_back(random_hex_char());
            seg.push_back(8'($urandom_range(255)));
         end else begin
            seg.push_back(fupc_pkg::CH_PERCENT);
            if ($urandom_range(1) == 1) seg.push_back(random_hex_char());
         end
      end
      foreach (seg[i]) push_item(seg[i], i == seg.size() - 1);
   endtask

   // Random phase: set mode and traffic, load strings, add pressure mid-phase
   task automatic run_phase(input logic m, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned target,
                            input bit long_hold, input bit pause_sender);
      int unsigned start;
      int unsigned queued;
      write_mode(m);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = items_accepted;
      queued = 0;
      while (queued < target) begin
         if (m == fupc_pkg::MODE_DECODE) gen_decode_string();
         else gen_encode_string();
         queued = req_items.size();
      end
      if (long_hold) begin
         while (items_accepted < start + 15) @(negedge clock);
         long_hold_req++;
      end
      if (pause_sender) begin
         while (items_accepted < start + 40) @(negedge clock);
         sender_hold = 1'b1;
         do @(negedge clock);
         while (req_valid || out_bytes_due.size() != 0);
         sender_hold = 1'b0;
      end
      wait_idle();
   endtask

   // Sequencer
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // encode extremes and every byte class, encode is the reset mode
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(fupc_pkg::CH_SPACE, 1'b0);
      push_text("z0_", 1'b0);
      push_item(8'h7E, 1'b1);

      // decode: mixed-case escape, plus, broken after percent and after a digit,
      // three-byte flush, lone percent and half escape at string end
      write_mode(fupc_pkg::MODE_DECODE);
      push_text("%Bc+", 1'b0);
      push_text("%G%4Z", 1'b0);
      push_text("%4%", 1'b1);
      push_text("%", 1'b1);
      push_text("%A", 1'b1);

      // a mode write while a partial sequence is held discards it
      push_text("%4", 1'b0);
      write_mode(fupc_pkg::MODE_DECODE);
      push_text("A", 1'b1);

      run_phase(fupc_pkg::MODE_ENCODE, 0, 0, 70, 1'b0, 1'b0);
      run_phase(fupc_pkg::MODE_DECODE, 79, 0, 70, 1'b0, 1'b1);
      run_phase(fupc_pkg::MODE_ENCODE, 0, 79, 70, 1'b1, 1'b0);
      run_phase(fupc_pkg::MODE_DECODE, 22, 22, 70, 1'b0, 1'b0);
      run_phase(fupc_pkg::MODE_DECODE, 0, 0, 70, 1'b1, 1'b1);
      run_phase(fupc_pkg::MODE_ENCODE, 22, 22, 70, 1'b0, 1'b1);

      if (out_bytes_due.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", out_bytes_due.size()));
      $display("run covered %0d encode and %0d decode bytes in %0d strings,",
               encode_items, decode_items, strings_sent);
      $display("with %0d result bytes checked and %0d mismatches", results_checked,
               error_count);
      if (error_count == 0) begin
         $display("form_url_percent_codec verification clean");
      end else begin
         $display("form_url_percent_codec verification failed");
      end
      $finish;
   end

endmodule
